### rtl/mcts_pkg.sv
package mcts_pkg;

    localparam int          CHANNELS    = 6;
    localparam int          CH_W        = 3;
    localparam logic [31:0] NS_PER_S    = 32'd1000000000;
    localparam logic [31:0] FREQ_RST    = 32'd62500000;
    localparam logic [63:0] ALL_ONES    = {64{1'b1}};
    localparam logic [6:0]  DIV_STEPS   = 7'd96;
    localparam logic [6:0]  RECIP_STEPS = 7'd9;
    // ceil(2^126 / 1e9): exact floor of any 96-bit value over 1e9 via bits [192:126]
    localparam logic [127:0] RECIP_NS   =
        ((128'd1 << 126) + 128'd999999999) / 128'd1000000000;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_READ = 2'd1,
        ACT_SET  = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PEND,
        ST_NOW_WAIT,
        ST_SET,
        ST_SCAN,
        ST_SCAN_END,
        ST_ARM_WAIT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SRC_TICK,
        SRC_ABS,
        SRC_BEST
    } t_md_src;

    typedef enum logic {
        MODE_TO_NS,
        MODE_TO_TICKS
    } t_md_mode;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL_LO,
        MD_MUL_HI,
        MD_ADD,
        MD_DIV,
        MD_RECIP
    } t_md_phase;

    typedef struct packed {
        logic     load;
        logic     fire;
        logic     md_start;
        t_md_src  md_src;
        t_md_mode md_mode;
        logic     now_cap;
        logic     set_store;
        logic     scan_init;
        logic     scan_step;
        logic     arm;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    hit;
        logic    ch_ok;
        logic    pending;
        logic    md_busy;
        logic    md_done;
        logic    arm_need;
        logic    scan_last;
        logic    found;
        logic    out_free;
    } t_sts;

endpackage

### rtl/mcts_if.sv
interface mcts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [2:0]  channel;
    logic [63:0] relative_timeout_ns;

    modport source (output valid, action, channel, relative_timeout_ns, input ready);
    modport sink   (input valid, action, channel, relative_timeout_ns, output ready);
endinterface

interface mcts_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  notify_mask;
    logic [63:0] time_ns;
    logic        time_valid;

    modport source (output valid, notify_mask, time_ns, time_valid, input ready);
    modport sink   (input valid, notify_mask, time_ns, time_valid, output ready);
endinterface

### rtl/mcts_muldiv.sv
module mcts_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  mcts_pkg::t_md_mode i_mode,
    input  logic [63:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_d,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_res
);
    import mcts_pkg::*;

    t_md_phase   r_phase;
    t_md_mode    r_mode;
    logic [6:0]  r_cnt;
    logic [63:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_d;
    logic [63:0] r_plo;
    logic [63:0] r_phi;
    logic [95:0] r_num;
    logic [31:0] r_rem;
    logic [97:0] r_acc;
    logic        r_done;
    logic [63:0] r_res;

    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        ge;
    logic [95:0] q_next;

    logic [31:0] rc_a;
    logic [31:0] rc_b;
    logic        rc_shift;
    logic        rc_hi;
    logic        rc_addn;
    logic [63:0] rc_prod;
    logic [97:0] rc_term;
    logic [97:0] rc_sum;
    logic [97:0] rc_next;

    always_comb begin
        rem_sh  = {r_rem, r_num[95]};
        ge      = rem_sh >= {1'b0, r_d};
        rem_sub = rem_sh - {1'b0, r_d};
        q_next  = {r_num[94:0], ge};
    end

    // ns to ticks: product times reciprocal of 1e9, column by column, low columns shifted out
    always_comb begin
        rc_a     = 32'd0;
        rc_b     = 32'd0;
        rc_shift = 1'b0;
        rc_hi    = 1'b0;
        rc_addn  = 1'b0;
        unique case (r_cnt)
            7'd0: begin
                rc_a = r_num[31:0];  rc_b = RECIP_NS[31:0];  rc_shift = 1'b1;
            end
            7'd1: begin
                rc_a = r_num[31:0];  rc_b = RECIP_NS[63:32];
            end
            7'd2: begin
                rc_a = r_num[63:32]; rc_b = RECIP_NS[31:0];  rc_shift = 1'b1;
            end
            7'd3: begin
                rc_a = r_num[31:0];  rc_b = RECIP_NS[95:64];
            end
            7'd4: begin
                rc_a = r_num[63:32]; rc_b = RECIP_NS[63:32];
            end
            7'd5: begin
                rc_a = r_num[95:64]; rc_b = RECIP_NS[31:0];  rc_shift = 1'b1;
            end
            7'd6: begin
                rc_a = r_num[63:32]; rc_b = RECIP_NS[95:64]; rc_addn = 1'b1;
            end
            7'd7: begin
                rc_a = r_num[95:64]; rc_b = RECIP_NS[63:32];
            end
            7'd8: begin
                rc_a = r_num[95:64]; rc_b = RECIP_NS[95:64]; rc_hi = 1'b1;
            end
            default: ;
        endcase
        rc_prod = 64'(rc_a * rc_b);
        rc_term = rc_hi ? {2'b00, rc_prod, 32'd0} : {34'd0, rc_prod};
        rc_sum  = r_acc + rc_term + (rc_addn ? {2'b00, r_num} : 98'd0);
        rc_next = rc_shift ? {32'd0, rc_sum[97:32]} : rc_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                MD_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_d     <= i_d;
                        r_mode  <= i_mode;
                        r_phase <= MD_MUL_LO;
                    end
                end
                MD_MUL_LO: begin
                    r_plo   <= 64'(r_a[31:0] * r_b);
                    r_phase <= MD_MUL_HI;
                end
                MD_MUL_HI: begin
                    r_phi   <= 64'(r_a[63:32] * r_b);
                    r_phase <= MD_ADD;
                end
                MD_ADD: begin
                    r_num   <= {r_phi, 32'd0} + {32'd0, r_plo};
                    r_rem   <= 32'd0;
                    r_acc   <= '0;
                    r_cnt   <= 7'd0;
                    r_phase <= (r_mode == MODE_TO_TICKS) ? MD_RECIP : MD_DIV;
                end
                MD_DIV: begin
                    r_rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
                    r_num <= q_next;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == DIV_STEPS - 7'd1) begin
                        r_res   <= (q_next[95:64] != 32'd0) ? ALL_ONES : q_next[63:0];
                        r_done  <= 1'b1;
                        r_phase <= MD_IDLE;
                    end
                end
                MD_RECIP: begin
                    r_acc <= rc_next;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == RECIP_STEPS - 7'd1) begin
                        r_res   <= (rc_sum[97:94] != 4'd0) ? ALL_ONES : rc_sum[93:30];
                        r_done  <= 1'b1;
                        r_phase <= MD_IDLE;
                    end
                end
                default: r_phase <= MD_IDLE;
            endcase
        end
    end

    assign o_busy = (r_phase != MD_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

### rtl/mcts_datapath.sv
module mcts_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  mcts_pkg::t_cmd i_cmd,
    output mcts_pkg::t_sts o_sts,
    mcts_in_if.sink       i_in,
    mcts_out_if.source    o_out,
    input  logic          i_in_ready
);
    import mcts_pkg::*;

    logic [31:0]   r_freq;
    t_action       r_act;
    logic [CH_W-1:0] r_ch;
    logic [63:0]   r_rel;
    logic [63:0]   r_tick;
    logic [63:0]   r_dl [CHANNELS];
    logic [63:0]   r_cmp;
    logic          r_armed;
    logic [63:0]   r_armed_dl;
    logic [CH_W-1:0] r_armed_ch;
    logic [CHANNELS-1:0] r_mask;
    logic [63:0]   r_time;
    logic [63:0]   r_now;
    logic [63:0]   r_best;
    logic [CH_W-1:0] r_best_ch;
    logic          r_found;
    logic [CH_W-1:0] r_idx;
    logic          r_ov;
    logic [5:0]    r_o_mask;
    logic [63:0]   r_o_time;
    logic          r_o_tv;

    logic [31:0] freq_eff;
    logic [64:0] abs_sum;
    logic [63:0] abs_ns;
    logic [63:0] md_a;
    logic [31:0] md_b;
    logic [31:0] md_d;
    logic        md_busy;
    logic        md_done;
    logic [63:0] md_res;
    logic [63:0] scan_dl;
    logic        pending;
    logic        out_free;

    always_comb begin
        freq_eff = (r_freq == 32'd0) ? 32'd1 : r_freq;
        abs_sum  = {1'b0, r_now} + {1'b0, r_rel};
        abs_ns   = abs_sum[64] ? ALL_ONES : abs_sum[63:0];
        unique case (i_cmd.md_src)
            SRC_TICK: md_a = r_tick;
            SRC_ABS:  md_a = abs_ns;
            default:  md_a = r_best;
        endcase
        md_d = freq_eff;
        if (i_cmd.md_mode == MODE_TO_NS) begin
            md_b = NS_PER_S;
        end else begin
            md_b = freq_eff;
        end
        pending = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (r_dl[i] != 64'd0) pending = 1'b1;
        end
        scan_dl  = r_dl[r_idx];
        out_free = !r_ov || o_out.ready;
    end

    mcts_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.md_start),
        .i_mode  (i_cmd.md_mode),
        .i_a     (md_a),
        .i_b     (md_b),
        .i_d     (md_d),
        .o_busy  (md_busy),
        .o_done  (md_done),
        .o_res   (md_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq     <= FREQ_RST;
            r_tick     <= 64'd0;
            for (int i = 0; i < CHANNELS; i++) r_dl[i] <= 64'd0;
            r_cmp      <= ALL_ONES;
            r_armed    <= 1'b0;
            r_armed_dl <= 64'd0;
            r_armed_ch <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) r_freq <= i_cfg_wdata;
            if (i_cmd.load) begin
                r_act  <= t_action'(i_in.action);
                r_ch   <= i_in.channel;
                r_rel  <= i_in.relative_timeout_ns;
                r_mask <= '0;
                r_time <= 64'd0;
                if (t_action'(i_in.action) == ACT_TICK) r_tick <= r_tick + 64'd1;
            end
            if (i_cmd.fire) begin
                r_cmp <= ALL_ONES;
                if (r_armed) begin
                    r_armed <= 1'b0;
                    if (32'(r_armed_ch) < CHANNELS) begin
                        r_dl[r_armed_ch]   <= 64'd0;
                        r_mask[r_armed_ch] <= 1'b1;
                    end
                end
            end
            if (i_cmd.now_cap) begin
                r_now <= md_res;
                if (r_act == ACT_READ) r_time <= md_res;
            end
            if (i_cmd.set_store) begin
                r_dl[r_ch] <= abs_ns;
                r_best     <= abs_ns;
                r_best_ch  <= r_ch;
            end
            if (i_cmd.scan_init) begin
                r_idx   <= '0;
                r_best  <= ALL_ONES;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
                if (scan_dl != 64'd0) begin
                    if (scan_dl <= r_now) begin
                        r_dl[r_idx]   <= 64'd0;
                        r_mask[r_idx] <= 1'b1;
                    end else if (scan_dl < r_best) begin
                        r_best    <= scan_dl;
                        r_best_ch <= r_idx;
                        r_found   <= 1'b1;
                    end
                end
            end
            if (i_cmd.arm) begin
                r_cmp      <= md_res;
                r_armed    <= 1'b1;
                r_armed_dl <= r_best;
                r_armed_ch <= r_best_ch;
            end
            if (i_cmd.emit) begin
                r_ov     <= 1'b1;
                r_o_mask <= r_mask;
                r_o_time <= r_time;
                r_o_tv   <= (r_act == ACT_READ);
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.act       = r_act;
        o_sts.hit       = r_tick >= r_cmp;
        o_sts.ch_ok     = 32'(r_ch) < CHANNELS;
        o_sts.pending   = pending;
        o_sts.md_busy   = md_busy;
        o_sts.md_done   = md_done;
        o_sts.arm_need  = !r_armed || (abs_ns < r_armed_dl);
        o_sts.scan_last = 32'(r_idx) == CHANNELS - 1;
        o_sts.found     = r_found;
        o_sts.out_free  = out_free;
    end

    assign i_in.ready        = i_in_ready;
    assign o_out.valid       = r_ov;
    assign o_out.notify_mask = r_o_mask;
    assign o_out.time_ns     = r_o_time;
    assign o_out.time_valid  = r_o_tv;
endmodule

### rtl/mcts_ctrl.sv
module mcts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mcts_pkg::t_sts i_sts,
    output mcts_pkg::t_cmd o_cmd,
    output logic           o_ready
);
    import mcts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_DECODE;
            ST_DECODE: begin
                unique case (i_sts.act)
                    ACT_TICK: n_state = i_sts.hit ? ST_PEND : ST_EMIT;
                    ACT_READ: n_state = ST_NOW_WAIT;
                    ACT_SET:  n_state = i_sts.ch_ok ? ST_NOW_WAIT : ST_EMIT;
                    default:  n_state = ST_EMIT;
                endcase
            end
            ST_PEND: n_state = i_sts.pending ? ST_NOW_WAIT : ST_EMIT;
            ST_NOW_WAIT: begin
                if (i_sts.md_done) begin
                    unique case (i_sts.act)
                        ACT_TICK: n_state = ST_SCAN;
                        ACT_SET:  n_state = ST_SET;
                        default:  n_state = ST_EMIT;
                    endcase
                end
            end
            ST_SET:      n_state = i_sts.arm_need ? ST_ARM_WAIT : ST_EMIT;
            ST_SCAN:     if (i_sts.scan_last) n_state = ST_SCAN_END;
            ST_SCAN_END: n_state = i_sts.found ? ST_ARM_WAIT : ST_EMIT;
            ST_ARM_WAIT: if (i_sts.md_done) n_state = ST_EMIT;
            ST_EMIT:     if (i_sts.out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.md_src  = SRC_TICK;
        o_cmd.md_mode = MODE_TO_NS;
        o_ready       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_DECODE: begin
                if (i_sts.act == ACT_TICK) o_cmd.fire = i_sts.hit;
                if (i_sts.act == ACT_READ || (i_sts.act == ACT_SET && i_sts.ch_ok)) begin
                    o_cmd.md_start = 1'b1;
                end
            end
            ST_PEND: o_cmd.md_start = i_sts.pending;
            ST_NOW_WAIT: begin
                o_cmd.now_cap   = i_sts.md_done;
                o_cmd.scan_init = i_sts.md_done && (i_sts.act == ACT_TICK);
            end
            ST_SET: begin
                o_cmd.set_store = 1'b1;
                o_cmd.md_start  = i_sts.arm_need;
                o_cmd.md_src    = SRC_ABS;
                o_cmd.md_mode   = MODE_TO_TICKS;
            end
            ST_SCAN: o_cmd.scan_step = 1'b1;
            ST_SCAN_END: begin
                o_cmd.md_start = i_sts.found;
                o_cmd.md_src   = SRC_BEST;
                o_cmd.md_mode  = MODE_TO_TICKS;
            end
            ST_ARM_WAIT: o_cmd.arm  = i_sts.md_done;
            ST_EMIT:     o_cmd.emit = i_sts.out_free;
            default: ;
        endcase
    end
endmodule

### rtl/multi_channel_timeout_scheduler_top.sv
// Channel  Dir  Word
// i_in     in   action, channel, relative_timeout_ns
// o_out    out  notify_mask, time_ns, time_valid
// i_cfg    in   tick_frequency_hz (write only)
//
// One word at a time; ready again once the result is in the output register. A tick
// without expiry converts nothing; an expiring tick converts only if a deadline is
// left, then scans and may arm; read converts once, set once more when it arms.
// Ticks to ns: two 32x32 products, then a 96-step restoring divide by the frequency.
// Ns to ticks: the same products, then nine 32x32 steps of a reciprocal multiply.
// Synchronous active-low reset; no clearing pass. The result sits in an output
// register, so a new word is taken while the previous result still waits.
module multi_channel_timeout_scheduler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    mcts_in_if.sink     i_in,
    mcts_out_if.source  o_out
);
    import mcts_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    mcts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_ready (in_ready)
    );

    mcts_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_in_ready  (in_ready)
    );

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free) else $error("result written over a pending one");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready) else $error("second word taken");

    a_md_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.md_start |-> !sts.md_busy) else $error("conversion started while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load && o_out.valid && !o_out.ready) |=> o_out.valid)
        else $error("pending result lost on accept");
endmodule
